>>> hdl/sppu_pkg.sv
// Shared types and constants for the sprite perspective projection unit.
package sppu_pkg;

  localparam int HEADING_ENTRIES_DEF = 1024;
  localparam int VIEW_COLUMNS_DEF    = 320;
  localparam int SCALE_LEVELS        = 16;

  localparam int NEAR_DIST   = 80;
  localparam int FAR_DIST    = 1122;
  localparam int PLAYER_DIST = 124;
  localparam int HALF_VIEW   = 160;
  localparam int PROJ_FACTOR = 37837;
  localparam int ROUND_MARK  = 8096;
  // 65536/70 rounded up, exact for offsets below 1000
  localparam int LEVEL_RECIP = 937;

  localparam int QW      = 23;  // quotient magnitude bits
  localparam int Q_DEPTH = 4;
  localparam int QCW     = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_HEAD = 2'd0,
    CMD_VIEW = 2'd1,
    CMD_PROJ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [9:0]         table_index;
    logic signed [31:0] table_word_a;
    logic signed [31:0] table_word_b;
    logic [15:0]        world_x;
    logic [15:0]        world_y;
    logic [15:0]        eye_x;
    logic [15:0]        eye_y;
    logic [15:0]        heading;
  } in_t;

  typedef struct packed {
    logic       visible;
    logic [8:0] screen_col;
    logic [10:0] distance;
    logic [3:0] size_level;
  } out_t;

  // queue entry: a view load or a project item with its heading entry
  typedef struct packed {
    logic               proj;
    logic               hd_ok;
    logic [9:0]         idx;
    logic signed [31:0] word_a;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
    logic signed [15:0] wy;
  } qent_t;

  typedef struct packed {
    logic room;
    logic nonempty;
  } qstat_t;

endpackage

>>> hdl/sppu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sppu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

>>> hdl/sppu_fifo.sv
// Short queue between the front and back parts.
module sppu_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sppu_pkg::qent_t push_data,
  input  logic          pop,
  output sppu_pkg::qent_t pop_data,
  output sppu_pkg::qstat_t stat
);
  import sppu_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  qent_t          buf_q [Q_DEPTH];
  logic [PW-1:0]  wptr;
  logic [PW-1:0]  rptr;
  logic [QCW-1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + QCW'(push) - QCW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) buf_q[wptr] <= push_data;
  end

  assign pop_data      = buf_q[rptr];
  assign stat.nonempty = (count != '0);
  // one beat may still be in the heading read stage, so keep two free
  assign stat.room     = (32'(count) <= Q_DEPTH - 2);
endmodule

>>> hdl/sppu_front.sv
// Front part: accepts beats, writes heading loads, fetches heading entries.
module sppu_front #(
  parameter int HEADING_ENTRIES = sppu_pkg::HEADING_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  sppu_pkg::in_t    in_data,
  input  sppu_pkg::qstat_t qstat,
  output logic             push,
  output sppu_pkg::qent_t  push_data
);
  import sppu_pkg::*;

  localparam int HAW = (HEADING_ENTRIES > 1) ? $clog2(HEADING_ENTRIES) : 1;

  logic          acc;
  logic          we;
  logic          re;
  logic [63:0]   rdata;
  logic          f1_valid;
  qent_t         f1;

  assign in_ready = qstat.room;
  assign acc      = in_valid && in_ready;
  assign we = acc && (cmd_t'(in_data.cmd) == CMD_HEAD)
              && (32'(in_data.table_index) < HEADING_ENTRIES);
  assign re = acc && (cmd_t'(in_data.cmd) == CMD_PROJ);

  sppu_ram #(.WIDTH(64), .DEPTH(HEADING_ENTRIES)) u_head_ram (
    .clk   (clk),
    .we    (we),
    .waddr (HAW'(in_data.table_index)),
    .wdata ({in_data.table_word_b, in_data.table_word_a}),
    .re    (re),
    .raddr (HAW'(in_data.heading)),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else begin
      f1_valid <= acc && ((cmd_t'(in_data.cmd) == CMD_PROJ)
                          || (cmd_t'(in_data.cmd) == CMD_VIEW));
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      f1.proj   <= (cmd_t'(in_data.cmd) == CMD_PROJ);
      f1.hd_ok  <= (32'(in_data.heading) < HEADING_ENTRIES);
      f1.idx    <= in_data.table_index;
      f1.word_a <= in_data.table_word_a;
      f1.tx     <= '0;
      f1.ty     <= '0;
      f1.dx     <= in_data.world_x - in_data.eye_x;
      f1.dy     <= in_data.world_y - in_data.eye_y;
      f1.wy     <= in_data.world_y;
    end
  end

  assign push = f1_valid;
  always_comb begin
    push_data    = f1;
    push_data.tx = rdata[31:0];
    push_data.ty = rdata[63:32];
  end
endmodule

>>> hdl/sppu_back.sv
// Back part: rotation, divide and root pipeline, view correction, scale level.
module sppu_back #(
  parameter int VIEW_COLUMNS = sppu_pkg::VIEW_COLUMNS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  sppu_pkg::qstat_t qstat,
  input  sppu_pkg::qent_t  qdata,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output sppu_pkg::out_t   out_data
);
  import sppu_pkg::*;

  localparam int VAW = (VIEW_COLUMNS > 1) ? $clog2(VIEW_COLUMNS) : 1;
  localparam int CW  = QW + 2;

  typedef struct packed {
    logic               v;
    logic               proj;
    logic               ok;
    logic [9:0]         idx;
    logic signed [31:0] wa;
    logic               qneg;
    logic               dzero;
    logic [16:0]        dmag;
    logic [QW-1:0]      n;
    logic [17:0]        rem;
    logic [QW-1:0]      q;
    logic [31:0]        x;
    logic [31:0]        res;
  } ds_t;

  function automatic ds_t ds_step(ds_t s, int k);
    ds_t         r;
    logic [17:0] rem2;
    logic [31:0] bitv;
    logic [31:0] t;
    r    = s;
    rem2 = {s.rem[16:0], s.n[QW-1]};
    r.n  = s.n << 1;
    if (rem2 >= {1'b0, s.dmag}) begin
      r.rem = rem2 - {1'b0, s.dmag};
      r.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      r.rem = rem2;
      r.q   = {s.q[QW-2:0], 1'b0};
    end
    if (k < 16) begin
      bitv = 32'd1 << (30 - 2 * k);
      t    = s.res + bitv;
      if (s.x >= t) begin
        r.x   = s.x - t;
        r.res = (s.res >> 1) + bitv;
      end else begin
        r.res = s.res >> 1;
      end
    end
    return r;
  endfunction

  logic en;

  // stage 0: products
  logic               v0, proj0, ok0, neg0;
  logic [9:0]         idx0;
  logic signed [31:0] wa0;
  logic signed [31:0] m_txdx, m_tydy, m_txdy, m_tydx;
  logic signed [47:0] f_txdx, f_tydy, f_txdy, f_tydx;

  // stage 1: forward and lateral
  logic               v1, proj1, ok1, neg1;
  logic [9:0]         idx1;
  logic signed [31:0] wa1;
  logic signed [15:0] fwd1, lat1;
  logic [31:0]        s_fwd, s_lat;
  logic signed [31:0] fwd_w, lat_w;

  // stage 2 and divide/root stages
  ds_t                b2;
  ds_t                b2_next;
  ds_t                ds [QW];
  ds_t                ds_in [QW];
  ds_t                ds_next [QW];
  ds_t                dl;
  logic signed [32:0] pf;
  logic signed [16:0] den_a;
  logic signed [16:0] den_v;
  logic signed [15:0] den16;
  logic signed [23:0] num;

  // column and view access
  logic signed [CW-1:0] qs;
  logic signed [CW-1:0] col;
  logic                 in_view;
  logic                 vwe, vre;
  logic [31:0]          vdata;
  logic                 v3, vis3;
  logic [8:0]           col3;
  logic [15:0]          root3;

  // correction
  logic                 v4, vis4, vnz4;
  logic [8:0]           col4;
  logic [15:0]          root4;
  logic signed [31:0]   prod4;
  logic signed [48:0]   prod_full;

  logic                 v5, vis5;
  logic [8:0]           col5;
  logic [10:0]          dist5;
  logic signed [18:0]   dcorr;

  logic signed [11:0]   off;
  logic [19:0]          lvl_p;
  logic [3:0]           lvl;

  assign en  = !out_valid || out_ready;
  assign pop = en && qstat.nonempty;

  assign f_txdx = qdata.tx * qdata.dx;
  assign f_tydy = qdata.ty * qdata.dy;
  assign f_txdy = qdata.tx * qdata.dy;
  assign f_tydx = qdata.ty * qdata.dx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= pop;
      v1 <= v0;
      v3 <= dl.v && dl.proj;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj0  <= qdata.proj;
      ok0    <= qdata.hd_ok;
      neg0   <= (qdata.dy < qdata.wy);
      idx0   <= qdata.idx;
      wa0    <= qdata.word_a;
      m_txdx <= f_txdx[31:0];
      m_tydy <= f_tydy[31:0];
      m_txdy <= f_txdy[31:0];
      m_tydx <= f_tydx[31:0];
    end
  end

  assign s_fwd = m_txdx + m_tydy;
  assign s_lat = m_txdy - m_tydx;

  always_ff @(posedge clk) begin
    if (en) begin
      proj1 <= proj0;
      ok1   <= ok0;
      neg1  <= neg0;
      idx1  <= idx0;
      wa1   <= wa0;
      fwd1  <= s_fwd[31:16];
      lat1  <= s_lat[31:16];
    end
  end

  // divisor: forward scaled by the projection factor, sign-flipped when neg1 is set, 16-bit
  assign pf    = fwd1 * 17'sd37837;
  assign den_a = pf[32:16];
  assign den_v = neg1 ? -den_a : den_a;
  assign den16 = den_v[15:0];
  assign num   = lat1 * 24'sd160;
  assign fwd_w = fwd1;
  assign lat_w = lat1;

  always_comb begin
    b2_next       = '0;
    b2_next.v     = v1;
    b2_next.proj  = proj1;
    b2_next.ok    = ok1 && (fwd1 > 16'sd0);
    b2_next.idx   = idx1;
    b2_next.wa    = wa1;
    b2_next.qneg  = num[23] ^ den16[15];
    b2_next.dzero = (den16 == 16'sd0);
    b2_next.dmag  = den16[15] ? 17'(-{den16[15], den16}) : {1'b0, den16};
    b2_next.n     = num[23] ? QW'(-num) : QW'(num);
    b2_next.x     = fwd_w * fwd_w + lat_w * lat_w;
  end

  always_comb begin
    for (int k = 0; k < QW; k++) begin
      ds_in[k]   = (k == 0) ? b2 : ds[(k == 0) ? 0 : k - 1];
      ds_next[k] = ds_step(ds_in[k], k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b2.v <= 1'b0;
      for (int k = 0; k < QW; k++) ds[k].v <= 1'b0;
    end else if (en) begin
      b2 <= b2_next;
      for (int k = 0; k < QW; k++) ds[k] <= ds_next[k];
    end
  end

  assign dl      = ds[QW-1];
  assign qs      = dl.qneg ? -$signed({2'b00, dl.q}) : $signed({2'b00, dl.q});
  assign col     = dl.dzero ? CW'(HALF_VIEW) : CW'(HALF_VIEW) - qs;
  assign in_view = (col >= 0) && (32'(col) < VIEW_COLUMNS);

  // view loads write and project lookups read the view table in beat order
  assign vwe = en && dl.v && !dl.proj && (32'(dl.idx) < VIEW_COLUMNS);
  assign vre = en && dl.v && dl.proj;

  sppu_ram #(.WIDTH(32), .DEPTH(VIEW_COLUMNS)) u_view_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (VAW'(dl.idx)),
    .wdata (dl.wa),
    .re    (vre),
    .raddr (VAW'(col)),
    .rdata (vdata)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      vis3  <= dl.ok && in_view;
      col3  <= col[8:0];
      root3 <= dl.res[15:0];
    end
  end

  assign prod_full = $signed({1'b0, root3}) * $signed(vdata);

  always_ff @(posedge clk) begin
    if (en) begin
      vis4  <= vis3;
      col4  <= col3;
      root4 <= root3;
      vnz4  <= (vdata != '0);
      prod4 <= prod_full[31:0];
    end
  end

  // floor shift by 14, bumped up when the dropped bits reach the mark; the root itself when the view entry is zero
  assign dcorr = vnz4 ? ({prod4[31], prod4[31:14]}
                         + 19'(prod4[13:0] >= 14'(ROUND_MARK)))
                      : $signed({3'b000, root4});

  always_ff @(posedge clk) begin
    if (en) begin
      vis5  <= vis4 && (dcorr >= 19'sd80) && (dcorr <= 19'sd1122);
      col5  <= col4;
      dist5 <= dcorr[10:0];
    end
  end

  assign off   = $signed({1'b0, dist5}) - 12'sd124;
  assign lvl_p = 20'(off[9:0]) * 20'(LEVEL_RECIP);

  always_comb begin
    if (off[11]) lvl = '0;
    else if (32'(lvl_p[19:16]) >= SCALE_LEVELS) lvl = 4'(SCALE_LEVELS - 1);
    else lvl = lvl_p[19:16];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.visible    <= vis5;
      out_data.screen_col <= vis5 ? col5 : '0;
      out_data.distance   <= vis5 ? dist5 : '0;
      out_data.size_level <= vis5 ? lvl : '0;
    end
  end
endmodule

>>> hdl/sprite_perspective_projection_unit.sv
// Top level of the sprite perspective projection unit.
// Load beats fill the heading table (cosine/sine pairs) and the per-column
// view correction table; a project beat returns one result beat with the
// screen column, corrected distance and scale level, or an invisible result.
// Loads and unknown commands return nothing. One beat is taken every cycle
// while results are drained; a project beat passes the heading read, the
// queue, the product stages and the 23-step divide pipeline that also runs
// the 16-step square root, then view correction and scale level. Heading
// loads take effect for every later beat; view loads are applied in beat
// order in the back pipeline.
module sprite_perspective_projection_unit #(
  parameter int HEADING_ENTRIES = sppu_pkg::HEADING_ENTRIES_DEF,
  parameter int VIEW_COLUMNS    = sppu_pkg::VIEW_COLUMNS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  sppu_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output sppu_pkg::out_t out_data
);
  import sppu_pkg::*;

  qstat_t qstat;
  logic   push;
  logic   pop;
  qent_t  push_data;
  qent_t  pop_data;

  sppu_front #(.HEADING_ENTRIES(HEADING_ENTRIES)) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .qstat     (qstat),
    .push      (push),
    .push_data (push_data)
  );

  sppu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .stat      (qstat)
  );

  sppu_back #(.VIEW_COLUMNS(VIEW_COLUMNS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .qstat     (qstat),
    .qdata     (pop_data),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
